[rtl/core/assert_macros.svh]
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic concurrent check, sampled on the rising clock, off during reset.
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal keeps its value from the cycle of the condition into the next one.
`define M3I_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) else $error(msg);

`endif

[rtl/core/m3i_pkg.sv]
`timescale 1ns / 1ps
package m3i_pkg;

	localparam int EW  = 32;      // entry width
	localparam int NE  = 9;       // entries per matrix
	localparam int PW  = 64;      // entry by entry product
	localparam int CW  = 65;      // cofactor, signed
	localparam int DW  = 98;      // determinant, signed
	localparam int DAW = 97;      // determinant magnitude
	localparam int QB  = 33;      // quotient bits kept by the divider
	localparam int QW  = QB + 1;  // quotient after rounding
	localparam int SW  = 66;      // sum of three products, signed

	localparam int FRONT_LAT = 6;
	localparam int DIV_LAT   = QB + 2;
	localparam int MERGE_LAT = 5;
	localparam int TOT_LAT   = FRONT_LAT + DIV_LAT + MERGE_LAT;

	localparam logic [QW-1:0] POS_MAX = QW'(64'd2147483647);
	localparam logic [QW-1:0] NEG_MAX = QW'(64'd2147483648);
	localparam logic [EW-1:0] INV_MAX = 32'h7FFF_FFFF;
	localparam logic [EW-1:0] INV_MIN = 32'h8000_0000;

	// cofactor i = m[A]*m[B] - m[C]*m[D], row-major adjugate
	localparam int unsigned COF_A [NE] = '{4, 2, 1, 5, 0, 3, 3, 1, 0};
	localparam int unsigned COF_B [NE] = '{8, 7, 5, 6, 8, 2, 7, 6, 4};
	localparam int unsigned COF_C [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned COF_D [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef logic signed [EW-1:0] ent_t;
	typedef logic [NE-1:0][EW-1:0] mat_t;

	typedef struct packed {
		ent_t m00;
		ent_t m01;
		ent_t m02;
		ent_t m10;
		ent_t m11;
		ent_t m12;
		ent_t m20;
		ent_t m21;
		ent_t m22;
	} in_t;

	typedef struct packed {
		logic        singular;
		logic [31:0] trip_error;
		logic        saturated;
		ent_t        inv00;
		ent_t        inv01;
		ent_t        inv02;
		ent_t        inv10;
		ent_t        inv11;
		ent_t        inv12;
		ent_t        inv20;
		ent_t        inv21;
		ent_t        inv22;
	} out_t;

	typedef struct packed {
		ent_t inv;
		logic sat;
	} lane_t;

endpackage

[rtl/core/m3i_front.sv]
`timescale 1ns / 1ps
module m3i_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  m3i_pkg::in_t                               din,
	input  logic [31:0]                                det_floor,
	output m3i_pkg::mat_t                              m_o,
	output logic [m3i_pkg::NE-1:0][m3i_pkg::CW-1:0]    adj_o,
	output logic [m3i_pkg::DAW-1:0]                    dabs_o,
	output logic                                       det_neg_o,
	output logic                                       sing_o
);

	localparam int NE = m3i_pkg::NE;
	localparam int PW = m3i_pkg::PW;
	localparam int CW = m3i_pkg::CW;
	localparam int DW = m3i_pkg::DW;
	localparam int DAW = m3i_pkg::DAW;
	localparam int LIM_PAD = DAW - 32 - 2 * FRAC_BITS;

	m3i_pkg::mat_t mi;
	m3i_pkg::mat_t m_s1, m_s2, m_s3, m_s4, m_s5, m_s6;
	logic [NE-1:0][PW-1:0] pa_s1, pb_s1;
	logic [NE-1:0][CW-1:0] adj_s2, adj_s3, adj_s4, adj_s5, adj_s6;
	logic [2:0][CW-1:0] plo_s3, phi_s3;
	logic [2:0][DW-1:0] term_s4;
	logic [DW-1:0] det_s5;
	logic [DW-1:0] dabs_c;
	logic [DAW-1:0] lim_c;
	logic [DAW-1:0] dabs_s6;
	logic det_neg_s6, sing_s6;

	assign mi = {din.m22, din.m21, din.m20, din.m12, din.m11, din.m10,
		din.m02, din.m01, din.m00};

	// stages 1-2: the two products of every cofactor, then their difference
	for (genvar gi = 0; gi < NE; gi++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[gi] <= $signed(mi[m3i_pkg::COF_A[gi]]) * $signed(mi[m3i_pkg::COF_B[gi]]);
				pb_s1[gi] <= $signed(mi[m3i_pkg::COF_C[gi]]) * $signed(mi[m3i_pkg::COF_D[gi]]);
				adj_s2[gi] <= $signed({pa_s1[gi][PW-1], pa_s1[gi]})
					- $signed({pb_s1[gi][PW-1], pb_s1[gi]});
			end
		end
	end

	// stages 3-4: determinant terms, cofactor split in a low and a high half
	for (genvar gj = 0; gj < 3; gj++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				plo_s3[gj] <= $signed(m_s2[gj]) * $signed({1'b0, adj_s2[3*gj][31:0]});
				phi_s3[gj] <= $signed(m_s2[gj]) * $signed(adj_s2[3*gj][CW-1:32]);
				term_s4[gj] <= {phi_s3[gj][CW-1], phi_s3[gj], 32'b0}
					+ {{(DW-CW){plo_s3[gj][CW-1]}}, plo_s3[gj]};
			end
		end
	end

	always_comb begin
		dabs_c = det_s5[DW-1] ? (~det_s5 + DW'(1)) : det_s5;
		lim_c  = {{LIM_PAD{1'b0}}, det_floor, {(2*FRAC_BITS){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= mi;
			m_s2 <= m_s1;
			m_s3 <= m_s2;
			m_s4 <= m_s3;
			m_s5 <= m_s4;
			m_s6 <= m_s5;
			adj_s3 <= adj_s2;
			adj_s4 <= adj_s3;
			adj_s5 <= adj_s4;
			adj_s6 <= adj_s5;
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			dabs_s6 <= dabs_c[DAW-1:0];
			det_neg_s6 <= det_s5[DW-1];
			sing_s6 <= (dabs_c[DAW-1:0] <= lim_c);
		end
	end

	assign m_o       = m_s6;
	assign adj_o     = adj_s6;
	assign dabs_o    = dabs_s6;
	assign det_neg_o = det_neg_s6;
	assign sing_o    = sing_s6;

endmodule

[rtl/core/m3i_div_lane.sv]
`timescale 1ns / 1ps
module m3i_div_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [m3i_pkg::CW-1:0]     adj,
	input  logic [m3i_pkg::DAW-1:0]    dabs,
	input  logic                       det_neg,
	output m3i_pkg::lane_t             res
);

	localparam int CW  = m3i_pkg::CW;
	localparam int PW  = m3i_pkg::PW;
	localparam int DAW = m3i_pkg::DAW;
	localparam int QB  = m3i_pkg::QB;
	localparam int QW  = m3i_pkg::QW;
	localparam int NW  = PW + 2 * FRAC_BITS;
	localparam int HW  = NW - QB;

	logic [CW-1:0] aabs_c;
	logic [NW-1:0] num_c;
	logic [DAW-1:0] head_c;

	// stage arrays, index = divider step
	logic [DAW-1:0] rem_s [QB+1];
	logic [DAW-1:0] dab_s [QB+1];
	logic [QB-1:0]  nlo_s [QB+1];
	logic [QB-1:0]  quo_s [QB+1];
	logic           neg_s [QB+1];
	logic           ovf_s [QB+1];

	logic rnd_c;
	logic [QW-1:0] qr_c, qn_c;
	logic sat_c;
	m3i_pkg::lane_t res_q;

	always_comb begin
		aabs_c = adj[CW-1] ? (~adj + CW'(1)) : adj;
		num_c  = {aabs_c[PW-1:0], {(2*FRAC_BITS){1'b0}}};
		head_c = {{(DAW-HW){1'b0}}, num_c[NW-1:QB]};
	end

	// quotient beyond QB bits means saturation, no need to find it
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head_c;
			dab_s[0] <= dabs;
			nlo_s[0] <= num_c[QB-1:0];
			quo_s[0] <= '0;
			neg_s[0] <= adj[CW-1] ^ det_neg;
			ovf_s[0] <= (head_c >= dabs);
		end
	end

	for (genvar gi = 0; gi < QB; gi++) begin : g_step
		logic [DAW:0] cand, diff;
		logic ge;
		always_comb begin
			cand = {rem_s[gi], nlo_s[gi][QB-1-gi]};
			diff = cand - {1'b0, dab_s[gi]};
			ge   = (cand >= {1'b0, dab_s[gi]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi+1] <= ge ? diff[DAW-1:0] : cand[DAW-1:0];
				dab_s[gi+1] <= dab_s[gi];
				nlo_s[gi+1] <= nlo_s[gi];
				quo_s[gi+1] <= {quo_s[gi][QB-2:0], ge};
				neg_s[gi+1] <= neg_s[gi];
				ovf_s[gi+1] <= ovf_s[gi];
			end
		end
	end

	// round half away from zero, then sign and saturate
	always_comb begin
		rnd_c = ({rem_s[QB], 1'b0} >= {1'b0, dab_s[QB]});
		qr_c  = {1'b0, quo_s[QB]} + QW'(rnd_c);
		qn_c  = ~qr_c + QW'(1);
		if (neg_s[QB]) begin
			sat_c = ovf_s[QB] || (qr_c > m3i_pkg::NEG_MAX);
		end else begin
			sat_c = ovf_s[QB] || (qr_c > m3i_pkg::POS_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.sat <= sat_c;
			if (neg_s[QB]) begin
				res_q.inv <= sat_c ? m3i_pkg::INV_MIN : qn_c[31:0];
			end else begin
				res_q.inv <= sat_c ? m3i_pkg::INV_MAX : qr_c[31:0];
			end
		end
	end

	assign res = res_q;

endmodule

[rtl/core/m3i_merge.sv]
`timescale 1ns / 1ps
module m3i_merge #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  m3i_pkg::mat_t                          m,
	input  m3i_pkg::lane_t [m3i_pkg::NE-1:0]       lanes,
	input  logic                                   sing,
	output m3i_pkg::out_t                          res
);

	localparam int NE  = m3i_pkg::NE;
	localparam int PW  = m3i_pkg::PW;
	localparam int SW  = m3i_pkg::SW;
	localparam int EQW = SW - FRAC_BITS;
	localparam int OW  = $bits(m3i_pkg::out_t);
	localparam logic [SW-1:0] TGT  = SW'(1) << (2 * FRAC_BITS);
	localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
	// singular flag is the top field, everything else zero
	localparam logic [OW-1:0] SING_RES = {1'b1, {(OW-1){1'b0}}};

	logic [3*NE-1:0][PW-1:0] prod_s1;
	logic [NE-1:0][SW-1:0] acc_s2;
	logic [NE-1:0][EQW-1:0] err_s3;
	logic [2:0][EQW-1:0] rmax_s4;
	m3i_pkg::mat_t inv_s1, inv_s2, inv_s3, inv_s4;
	logic [NE-1:0] sat_s1, sat_s2, sat_s3, sat_s4;
	logic sing_s1, sing_s2, sing_s3, sing_s4;
	m3i_pkg::out_t res_s5;
	logic [EQW-1:0] emax_c;
	logic esat_c;

	// product M * inv, entry (r,c) from three lanes of column c
	for (genvar gr = 0; gr < 3; gr++) begin : g_row
		for (genvar gc = 0; gc < 3; gc++) begin : g_col
			localparam int RC = gr * 3 + gc;
			logic [SW-1:0] aabs, rsum;
			for (genvar gk = 0; gk < 3; gk++) begin : g_k
				always_ff @(posedge clk) begin
					if (en) begin
						prod_s1[RC*3+gk] <= $signed(m[gr*3+gk])
							* $signed(lanes[gk*3+gc].inv);
					end
				end
			end
			always_comb begin
				aabs = acc_s2[RC][SW-1] ? (~acc_s2[RC] + SW'(1)) : acc_s2[RC];
				rsum = aabs + HALF;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					acc_s2[RC] <= {{2{prod_s1[RC*3][PW-1]}}, prod_s1[RC*3]}
						+ {{2{prod_s1[RC*3+1][PW-1]}}, prod_s1[RC*3+1]}
						+ {{2{prod_s1[RC*3+2][PW-1]}}, prod_s1[RC*3+2]}
						- ((gr == gc) ? TGT : '0);
					err_s3[RC] <= rsum[SW-1:FRAC_BITS];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rmax_s4[gr] <= (err_s3[gr*3] >= err_s3[gr*3+1])
					? ((err_s3[gr*3] >= err_s3[gr*3+2]) ? err_s3[gr*3] : err_s3[gr*3+2])
					: ((err_s3[gr*3+1] >= err_s3[gr*3+2]) ? err_s3[gr*3+1] : err_s3[gr*3+2]);
			end
		end
	end

	always_comb begin
		emax_c = (rmax_s4[0] >= rmax_s4[1])
			? ((rmax_s4[0] >= rmax_s4[2]) ? rmax_s4[0] : rmax_s4[2])
			: ((rmax_s4[1] >= rmax_s4[2]) ? rmax_s4[1] : rmax_s4[2]);
		esat_c = (emax_c[EQW-1:32] != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NE; i++) begin
				inv_s1[i] <= lanes[i].inv;
				sat_s1[i] <= lanes[i].sat;
			end
			inv_s2 <= inv_s1;
			inv_s3 <= inv_s2;
			inv_s4 <= inv_s3;
			sat_s2 <= sat_s1;
			sat_s3 <= sat_s2;
			sat_s4 <= sat_s3;
			sing_s1 <= sing;
			sing_s2 <= sing_s1;
			sing_s3 <= sing_s2;
			sing_s4 <= sing_s3;
			if (sing_s4) begin
				res_s5 <= SING_RES;
			end else begin
				res_s5.singular   <= 1'b0;
				res_s5.trip_error <= esat_c ? 32'hFFFF_FFFF : emax_c[31:0];
				res_s5.saturated  <= esat_c || (sat_s4 != '0);
				res_s5.inv00 <= inv_s4[0];
				res_s5.inv01 <= inv_s4[1];
				res_s5.inv02 <= inv_s4[2];
				res_s5.inv10 <= inv_s4[3];
				res_s5.inv11 <= inv_s4[4];
				res_s5.inv12 <= inv_s4[5];
				res_s5.inv20 <= inv_s4[6];
				res_s5.inv21 <= inv_s4[7];
				res_s5.inv22 <= inv_s4[8];
			end
		end
	end

	assign res = res_s5;

endmodule

[rtl/core/matrix3_inverse_with_check.sv]
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// in      | in  | in_valid/in_stall | in_data (m3i_pkg::in_t, nine Q16.16 entries)
// out     | out | out_valid/out_stall | out_data (m3i_pkg::out_t, flags, error, inverse)
// cfg     | in  | cfg_we           | cfg_wdata (det_floor, reset 1)
//
// One transaction per cycle sustained while the skid entry is free (in_stall low).
// Most of the latency is in the 33-step restoring divider in each of the nine lanes.
// arst_n clears valid flags and the skid flag and sets det_floor to 1; payload flops are not reset.
// A stalled output holds in the output register; the next transaction lands in
// the skid register, then the whole pipe freezes (in_stall is a registered flag).
`include "assert_macros.svh"
module matrix3_inverse_with_check #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  m3i_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output m3i_pkg::out_t  out_data
);

	localparam int NE      = m3i_pkg::NE;
	localparam int TOT_LAT = m3i_pkg::TOT_LAT;
	localparam int DIV_LAT = m3i_pkg::DIV_LAT;

	logic [31:0] det_floor_q;
	logic [TOT_LAT-1:0] vld_q;
	logic en;

	m3i_pkg::mat_t front_m;
	logic [NE-1:0][m3i_pkg::CW-1:0] front_adj;
	logic [m3i_pkg::DAW-1:0] front_dabs;
	logic front_neg, front_sing;
	m3i_pkg::lane_t [NE-1:0] lane_res;

	// matrix and singular flag ride alongside the divider lanes
	m3i_pkg::mat_t m_dly [DIV_LAT];
	logic sing_dly [DIV_LAT];

	m3i_pkg::out_t tail;
	logic tail_v;
	m3i_pkg::out_t out_q, skid_q;
	logic out_valid_q, skid_v_q, out_take;

	// whole pipe advances together unless the skid entry is occupied
	assign en       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_floor_q <= 32'd1;
		end else if (cfg_we) begin
			det_floor_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT_LAT-2:0], in_valid};
		end
	end

	m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.en        (en),
		.din       (in_data),
		.det_floor (det_floor_q),
		.m_o       (front_m),
		.adj_o     (front_adj),
		.dabs_o    (front_dabs),
		.det_neg_o (front_neg),
		.sing_o    (front_sing)
	);

	// one divider lane per inverse entry
	for (genvar gi = 0; gi < NE; gi++) begin : g_lane
		m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.en      (en),
			.adj     (front_adj[gi]),
			.dabs    (front_dabs),
			.det_neg (front_neg),
			.res     (lane_res[gi])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_dly[0]    <= front_m;
			sing_dly[0] <= front_sing;
			for (int i = 1; i < DIV_LAT; i++) begin
				m_dly[i]    <= m_dly[i-1];
				sing_dly[i] <= sing_dly[i-1];
			end
		end
	end

	m3i_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk   (clk),
		.en    (en),
		.m     (m_dly[DIV_LAT-1]),
		.lanes (lane_res),
		.sing  (sing_dly[DIV_LAT-1]),
		.res   (tail)
	);

	assign tail_v   = vld_q[TOT_LAT-1];
	assign out_take = out_valid_q && !out_stall;

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (out_take) begin
					skid_v_q <= 1'b0;
				end
			end else if (tail_v) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (tail_v) begin
			if (!out_valid_q || out_take) begin
				out_q <= tail;
			end else begin
				skid_q <= tail;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`M3I_ASSERT(a_skid_has_out, clk, arst_n, skid_v_q |-> out_valid_q, "skid entry without output")
	`M3I_ASSERT_HOLD(a_pipe_frozen, clk, arst_n, skid_v_q, vld_q, "pipe moved while skid full")
	`M3I_ASSERT(a_sing_zero, clk, arst_n, (out_valid_q && out_q.singular) |-> (out_q.trip_error == 32'd0 && !out_q.saturated && out_q.inv11 == 32'sd0), "singular result not zero")
	`M3I_ASSERT(a_tail_to_skid, clk, arst_n, (tail_v && !skid_v_q && out_valid_q && out_stall) |=> skid_v_q, "stalled tail transaction lost")

endmodule
